// File: hdl/mspt_pkg.sv
// mspt_pkg: shared widths, codes and types of the multi-slot periodic timer
// no dependencies; used by every file of the block

package mspt_pkg;

  // field widths fixed by the item format
  localparam int FUNC_W = 2;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 32;

  // default slot count and depth of the command queue
  localparam int NUM_SLOTS_DEF = 16;
  localparam int CMDQ_DEPTH    = 2;

  // function codes as they arrive on the input channel
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_START,
    OP_STOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] duration;
    logic              repeat_req;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DIV,
    BK_FLUSH
  } back_state_e;

  // remainder unit request and response
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] rem;
  } rem_rsp_t;

endpackage

// File: hdl/mspt_if.sv
// mspt_in_if / mspt_out_if: valid-ready channels of the periodic timer
// depends on mspt_pkg for field widths

interface mspt_in_if;
  logic                          valid;
  logic                          ready;
  logic [mspt_pkg::FUNC_W-1:0]   func;
  logic [mspt_pkg::SLOT_W-1:0]   slot;
  logic [mspt_pkg::TIME_W-1:0]   duration;
  logic                          repeat_req;
  logic [mspt_pkg::TIME_W-1:0]   now;

  modport source (output valid, func, slot, duration, repeat_req, now, input ready);
  modport sink   (input valid, func, slot, duration, repeat_req, now, output ready);
endinterface

interface mspt_out_if;
  logic                          valid;
  logic                          ready;
  logic [mspt_pkg::SLOT_W-1:0]   fired_slot;
  logic [mspt_pkg::TIME_W-1:0]   lateness;
  logic                          last_alarm;

  modport source (output valid, fired_slot, lateness, last_alarm, input ready);
  modport sink   (input valid, fired_slot, lateness, last_alarm, output ready);
endinterface

// File: hdl/multi_slot_periodic_timer_top.sv
// multi_slot_periodic_timer_top: command queue front, slot sequencer back
// depends on mspt_pkg, mspt_if, mspt_front, mspt_rem, mspt_back
//
//   port    dir  payload                                   done when
//   in_i    in   func, slot, duration, repeat_req, now     valid && ready
//   out_o   out  fired_slot, lateness, last_alarm          valid && ready
//
// start and stop are handled by the idle back end; a tick reads the slot memory
// one slot per cycle, unless the output or the remainder unit holds the scan
// each repeating slot late by a whole period or more also takes a pass through
// the bit-serial remainder unit
// the last alarm of a tick leaves only once the scan has ended
// reset clears all active marks at once; no clearing pass
// a two-word queue lets the input take words while the back end scans

module multi_slot_periodic_timer_top #(
  parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mspt_in_if.sink     in_i,
  mspt_out_if.source  out_o
);

  logic                 cmd_valid;
  logic                 cmd_ready;
  mspt_pkg::cmd_t       cmd;
  mspt_pkg::rem_req_t   rem_req;
  mspt_pkg::rem_rsp_t   rem_rsp;

  // accept and classify
  mspt_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // catch-up remainder
  mspt_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  // slot sequencer
  mspt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rem_req_o   (rem_req),
    .rem_rsp_i   (rem_rsp),
    .out_o       (out_o)
  );

endmodule

// File: hdl/mspt_front.sv
// mspt_front: accepts input words, drops ones that do nothing, queues commands
// depends on mspt_pkg and mspt_in_if

module mspt_front #(
  parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  mspt_in_if.sink             in_i,
  output logic                cmd_valid_o,
  output mspt_pkg::cmd_t      cmd_o,
  input  logic                cmd_ready_i
);

  localparam int PW = (mspt_pkg::CMDQ_DEPTH > 1) ? $clog2(mspt_pkg::CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(mspt_pkg::CMDQ_DEPTH + 1);

  mspt_pkg::cmd_t   q_mem [mspt_pkg::CMDQ_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             keep;
  logic             slot_ok;
  logic             push, pop;
  mspt_pkg::cmd_t   cmd_new;

  // classify the incoming word
  assign slot_ok = (32'(in_i.slot) < NUM_SLOTS);

  always_comb begin
    keep           = 1'b0;
    cmd_new.op     = mspt_pkg::OP_TICK;
    cmd_new.slot   = in_i.slot;
    cmd_new.duration   = in_i.duration;
    cmd_new.repeat_req = in_i.repeat_req;
    cmd_new.now    = in_i.now;
    case (in_i.func)
      mspt_pkg::FUNC_TICK: begin
        keep       = 1'b1;
        cmd_new.op = mspt_pkg::OP_TICK;
      end
      mspt_pkg::FUNC_START: begin
        keep       = slot_ok;
        cmd_new.op = mspt_pkg::OP_START;
      end
      mspt_pkg::FUNC_STOP: begin
        keep       = slot_ok;
        cmd_new.op = mspt_pkg::OP_STOP;
      end
      default: keep = 1'b0;
    endcase
  end

  // queue handshake
  assign in_i.ready  = (cnt_q != CW'(mspt_pkg::CMDQ_DEPTH));
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(mspt_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(mspt_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: hdl/mspt_rem.sv
// mspt_rem: restoring remainder unit, one quotient bit per cycle
// depends on mspt_pkg

module mspt_rem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mspt_pkg::rem_req_t  req_i,
  output mspt_pkg::rem_rsp_t  rsp_o
);

  localparam int TW  = mspt_pkg::TIME_W;
  localparam int NW  = $clog2(TW + 1);

  logic            busy_q;
  logic            done_q;
  logic [NW-1:0]   cnt_q;
  logic [TW-1:0]   num_q;
  logic [TW-1:0]   den_q;
  logic [TW-1:0]   r_q, r_d;
  logic [TW:0]     shifted;
  logic [TW:0]     diff;

  // one restoring step
  assign shifted = {r_q, num_q[TW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    if (shifted >= {1'b0, den_q}) begin
      r_d = diff[TW-1:0];
    end else begin
      r_d = shifted[TW-1:0];
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(TW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      r_q   <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[TW-2:0], 1'b0};
      r_q   <= r_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;

endmodule

// File: hdl/mspt_back.sv
// mspt_back: runs start, stop and tick commands over the slot memory
// depends on mspt_pkg and mspt_out_if; drives the remainder unit

module mspt_back #(
  parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  mspt_pkg::cmd_t      cmd_i,
  output logic                cmd_ready_o,
  output mspt_pkg::rem_req_t  rem_req_o,
  input  mspt_pkg::rem_rsp_t  rem_rsp_i,
  mspt_out_if.source          out_o
);

  localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int TW = mspt_pkg::TIME_W;
  localparam int SW = mspt_pkg::SLOT_W;

  mspt_pkg::back_state_e state_q, state_d;

  // slot memory, undefined until a start writes an entry
  logic [TW-1:0]   exp_mem [NUM_SLOTS];
  logic [TW-1:0]   per_mem [NUM_SLOTS];
  logic            rep_mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] act_q;

  logic [TW-1:0]   tnow_q;
  logic [CW-1:0]   rd_cnt_q;
  logic            s1_v_q;
  logic [AW-1:0]   s1_idx_q;
  logic [TW-1:0]   exp_rd_q;
  logic [TW-1:0]   per_rd_q;
  logic            rep_rd_q;

  logic            pend_v_q;
  logic [SW-1:0]   pend_slot_q;
  logic [TW-1:0]   pend_late_q;
  logic            out_v_q;
  logic [SW-1:0]   out_slot_q;
  logic [TW-1:0]   out_late_q;
  logic            out_last_q;

  logic            rd_more, due, keep_arm, slow, out_free, emit_ok, fire, s1_go, s1_step;
  logic [TW-1:0]   gap;
  logic            rd_en;
  logic            mem_we_exp, mem_we_cfg;
  logic [AW-1:0]   mem_waddr;
  logic [TW-1:0]   mem_wexp;
  logic            act_set, act_clr;
  logic [AW-1:0]   act_addr;
  logic            tick_load, s1_clear, flush_load, out_mid_load;

  // stage one checks of the slot just read
  assign rd_more  = (rd_cnt_q != CW'(NUM_SLOTS));
  assign gap      = tnow_q - exp_rd_q;
  assign due      = s1_v_q && act_q[s1_idx_q] && (tnow_q >= exp_rd_q);
  assign keep_arm = rep_rd_q && (per_rd_q != '0);
  assign slow     = keep_arm && (gap >= per_rd_q);
  assign out_free = !out_v_q || out_o.ready;
  assign emit_ok  = !pend_v_q || out_free;
  assign fire     = (state_q == mspt_pkg::BK_SCAN) && due && emit_ok;
  assign s1_go    = !s1_v_q || !due || emit_ok;
  assign s1_step  = (state_q == mspt_pkg::BK_SCAN) && s1_go && !(fire && slow);
  assign rd_en    = s1_step && rd_more;
  assign out_mid_load = fire && pend_v_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mspt_pkg::BK_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == mspt_pkg::OP_TICK)) begin
          state_d = mspt_pkg::BK_SCAN;
        end
      end
      mspt_pkg::BK_SCAN: begin
        if (fire && slow) begin
          state_d = mspt_pkg::BK_DIV;
        end else if (!s1_v_q && !rd_more) begin
          state_d = mspt_pkg::BK_FLUSH;
        end
      end
      mspt_pkg::BK_DIV: begin
        if (rem_rsp_i.done) begin
          state_d = mspt_pkg::BK_SCAN;
        end
      end
      mspt_pkg::BK_FLUSH: begin
        if (!pend_v_q || out_free) begin
          state_d = mspt_pkg::BK_IDLE;
        end
      end
      default: state_d = mspt_pkg::BK_IDLE;
    endcase
  end

  // per-state controls
  always_comb begin
    cmd_ready_o   = 1'b0;
    mem_we_exp    = 1'b0;
    mem_we_cfg    = 1'b0;
    mem_waddr     = s1_idx_q;
    mem_wexp      = exp_rd_q + per_rd_q;
    act_set       = 1'b0;
    act_clr       = 1'b0;
    act_addr      = s1_idx_q;
    tick_load     = 1'b0;
    s1_clear      = 1'b0;
    flush_load    = 1'b0;
    rem_req_o.start = 1'b0;
    rem_req_o.num   = gap;
    rem_req_o.den   = per_rd_q;
    case (state_q)
      mspt_pkg::BK_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          case (cmd_i.op)
            mspt_pkg::OP_START: begin
              mem_we_exp = 1'b1;
              mem_we_cfg = 1'b1;
              mem_waddr  = AW'(cmd_i.slot);
              mem_wexp   = cmd_i.now + cmd_i.duration;
              act_set    = 1'b1;
              act_addr   = AW'(cmd_i.slot);
            end
            mspt_pkg::OP_STOP: begin
              act_clr  = 1'b1;
              act_addr = AW'(cmd_i.slot);
            end
            mspt_pkg::OP_TICK: tick_load = 1'b1;
            default: ;
          endcase
        end
      end
      mspt_pkg::BK_SCAN: begin
        if (fire) begin
          if (slow) begin
            rem_req_o.start = 1'b1;
          end else if (keep_arm) begin
            mem_we_exp = 1'b1;
          end else begin
            act_clr = 1'b1;
          end
        end
      end
      mspt_pkg::BK_DIV: begin
        // next expiry is now + period - (gap mod period)
        if (rem_rsp_i.done) begin
          mem_we_exp = 1'b1;
          mem_wexp   = tnow_q + per_rd_q - rem_rsp_i.rem;
          s1_clear   = 1'b1;
        end
      end
      mspt_pkg::BK_FLUSH: flush_load = pend_v_q && out_free;
      default: ;
    endcase
  end

  // slot memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we_exp) begin
      exp_mem[mem_waddr] <= mem_wexp;
    end
    if (mem_we_cfg) begin
      per_mem[mem_waddr] <= cmd_i.duration;
      rep_mem[mem_waddr] <= cmd_i.repeat_req;
    end
    if (rd_en) begin
      exp_rd_q <= exp_mem[rd_cnt_q[AW-1:0]];
      per_rd_q <= per_mem[rd_cnt_q[AW-1:0]];
      rep_rd_q <= rep_mem[rd_cnt_q[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mspt_pkg::BK_IDLE;
      act_q    <= '0;
      rd_cnt_q <= '0;
      s1_v_q   <= 1'b0;
      s1_idx_q <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (act_set) begin
        act_q[act_addr] <= 1'b1;
      end else if (act_clr) begin
        act_q[act_addr] <= 1'b0;
      end
      if (tick_load) begin
        rd_cnt_q <= '0;
        s1_v_q   <= 1'b0;
      end else if (s1_step) begin
        s1_v_q <= rd_more;
        if (rd_more) begin
          s1_idx_q <= rd_cnt_q[AW-1:0];
          rd_cnt_q <= rd_cnt_q + 1'b1;
        end
      end else if (s1_clear) begin
        s1_v_q <= 1'b0;
      end
      if (fire) begin
        pend_v_q <= 1'b1;
      end else if (flush_load) begin
        pend_v_q <= 1'b0;
      end
      if (out_mid_load || flush_load) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers: tick time, held alarm and output word
  always_ff @(posedge clk_i) begin
    if (tick_load) begin
      tnow_q <= cmd_i.now;
    end
    if (fire) begin
      pend_slot_q <= SW'(s1_idx_q);
      pend_late_q <= gap;
    end
    if (out_mid_load || flush_load) begin
      out_slot_q <= pend_slot_q;
      out_late_q <= pend_late_q;
      out_last_q <= flush_load;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.fired_slot = out_slot_q;
  assign out_o.lateness   = out_late_q;
  assign out_o.last_alarm = out_last_q;

endmodule

// File: hdl/mspt_check.sv
// mspt_check: port-level assertions of the periodic timer, bound to the top
// depends on mspt_pkg and multi_slot_periodic_timer_top

module mspt_check #(
  parameter int NUM_SLOTS = mspt_pkg::NUM_SLOTS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [mspt_pkg::FUNC_W-1:0] in_func_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mspt_pkg::SLOT_W-1:0] out_slot_i,
  input logic [mspt_pkg::TIME_W-1:0] out_late_i,
  input logic                        out_last_i
);

  logic                        tick_seen_q;
  logic                        mid_q;
  logic [mspt_pkg::SLOT_W-1:0] prev_slot_q;

  // track ticks and the alarms of the current tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_seen_q <= 1'b0;
      mid_q       <= 1'b0;
      prev_slot_q <= '0;
    end else begin
      if (in_valid_i && in_ready_i && (in_func_i == mspt_pkg::FUNC_TICK)) begin
        tick_seen_q <= 1'b1;
      end
      if (out_valid_i && out_ready_i) begin
        mid_q       <= !out_last_i;
        prev_slot_q <= out_slot_i;
      end
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i)
      && $stable(out_late_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // alarms name an existing slot
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(out_slot_i) < NUM_SLOTS))
    else $error("alarm names a slot beyond the array");

  // no alarm before the first tick
  a_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> tick_seen_q)
    else $error("alarm without any tick");

  // alarms of one tick come in rising slot order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mid_q |-> (out_slot_i > prev_slot_q))
    else $error("alarms of one tick out of slot order");

endmodule

bind multi_slot_periodic_timer_top mspt_check #(
  .NUM_SLOTS (NUM_SLOTS)
) u_mspt_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_slot_i  (out_o.fired_slot),
  .out_late_i  (out_o.lateness),
  .out_last_i  (out_o.last_alarm)
);
